// ----- rtl/core/isc_pkg.sv -----
// Package for the indexed stack with compaction.
// Holds request codes, status codes and the sequencer state type.
// No dependencies.
package isc_pkg;

    // Request codes
    localparam logic [2:0] MODE_PUSH      = 3'd0;
    localparam logic [2:0] MODE_POP       = 3'd1;
    localparam logic [2:0] MODE_GET       = 3'd2;
    localparam logic [2:0] MODE_SET       = 3'd3;
    localparam logic [2:0] MODE_ERASE     = 3'd4;
    localparam logic [2:0] MODE_ERASE_RUN = 3'd5;
    localparam logic [2:0] MODE_BACK      = 3'd6;
    localparam logic [2:0] MODE_CLEAR     = 3'd7;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam int VALUE_W = 64;
    localparam int FILL_W  = 5;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_RDWAIT = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

endpackage

// ----- rtl/core/isc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module isc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/indexed_stack_with_compaction.sv -----
// Top level of the indexed stack with compaction: fixed-capacity vector of
// 64-bit entries kept in one RAM. Depends on isc_pkg and isc_ram.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------------
//   request | req_valid | req_stall | mode, position, erase_count, item_value
//   result  | rsp_valid | rsp_stall | read_value, status, fill_count, is_empty
//
// One request is in work at a time. Every request passes through the exec and
// response states; get and back also pass the read-wait state for the RAM read.
// Erase moves each later entry down through the RAM read/write ports, one
// entry per cycle, in the shift state before the response state.
// Reset clears the fill count and control state; the entries themselves are
// not cleared, since only entries below the fill count are ever read.
// A stalled result sits in the output register while the next request is
// taken; the sequencer holds in its response state until that register frees.
module indexed_stack_with_compaction #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  mode,
    input  logic [3:0]  position,
    input  logic [4:0]  erase_count,
    input  logic [63:0] item_value,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] read_value,
    output logic [1:0]  status,
    output logic [4:0]  fill_count,
    output logic        is_empty
);

    // Count width holds 0..CAPACITY; address width indexes the entries.
    // Comparison width covers position + erase_count and the count.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    isc_pkg::state_t state_reg, state_next;

    logic [2:0]                     mode_reg;
    logic [3:0]                     pos_reg;
    logic [4:0]                     cut_reg;
    logic [isc_pkg::VALUE_W-1:0]    item_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] src_reg, src_next;
    logic [CW-1:0] dst_reg, dst_next;
    logic          pend_reg, pend_next;

    logic [isc_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [1:0]                  res_status_reg, res_status_next;

    logic                        rsp_valid_reg;
    logic [isc_pkg::VALUE_W-1:0] read_value_reg;
    logic [1:0]                  status_reg;
    logic [isc_pkg::FILL_W-1:0]  fill_reg;
    logic                        empty_reg;

    // RAM port signals
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [isc_pkg::VALUE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [isc_pkg::VALUE_W-1:0] ram_rdata;

    logic [XW-1:0] pos_x, cut_x, count_x, cap_x, end_x;
    logic [CW-1:0] count_dec;
    logic          req_xfer, rsp_xfer, rsp_load, issue;

    isc_ram #(
        .WIDTH (isc_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != isc_pkg::ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_xfer  = rsp_valid_reg && !rsp_stall;
    // Load the output register when it is empty or being drained this cycle.
    assign rsp_load  = (state_reg == isc_pkg::ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    assign pos_x     = XW'(pos_reg);
    assign cut_x     = XW'(cut_reg);
    assign count_x   = XW'(count_reg);
    assign cap_x     = XW'(CAPACITY);
    assign end_x     = pos_x + cut_x;
    assign count_dec = count_reg - CW'(1);
    // Another entry remains to move while the source is below the count.
    assign issue     = (src_reg < count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        pend_next       = 1'b0;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = item_reg;
        ram_re          = 1'b0;
        ram_raddr       = pos_x[AW-1:0];

        case (state_reg)
            isc_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = isc_pkg::ST_EXEC;
                end
            end

            isc_pkg::ST_EXEC:
            begin
                res_value_next  = '0;
                res_status_next = isc_pkg::STATUS_OK;
                state_next      = isc_pkg::ST_RESP;
                case (mode_reg)
                    isc_pkg::MODE_PUSH:
                    begin
                        if (count_x >= cap_x)
                        begin
                            res_status_next = isc_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    isc_pkg::MODE_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = isc_pkg::STATUS_BOUND;
                        end
                        else
                        begin
                            count_next = count_dec;
                        end
                    end
                    isc_pkg::MODE_GET:
                    begin
                        if (pos_x >= count_x)
                        begin
                            res_status_next = isc_pkg::STATUS_BOUND;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_x[AW-1:0];
                            state_next = isc_pkg::ST_RDWAIT;
                        end
                    end
                    isc_pkg::MODE_SET:
                    begin
                        if (pos_x >= count_x)
                        begin
                            res_status_next = isc_pkg::STATUS_BOUND;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_x[AW-1:0];
                        end
                    end
                    isc_pkg::MODE_ERASE:
                    begin
                        if (pos_x >= count_x)
                        begin
                            res_status_next = isc_pkg::STATUS_BOUND;
                        end
                        else
                        begin
                            src_next   = CW'(pos_x + XW'(1));
                            dst_next   = CW'(pos_x);
                            state_next = isc_pkg::ST_SHIFT;
                        end
                    end
                    isc_pkg::MODE_ERASE_RUN:
                    begin
                        if ((pos_x >= count_x) || (end_x > count_x))
                        begin
                            res_status_next = isc_pkg::STATUS_BOUND;
                        end
                        else if (cut_reg != '0)
                        begin
                            src_next   = CW'(end_x);
                            dst_next   = CW'(pos_x);
                            state_next = isc_pkg::ST_SHIFT;
                        end
                    end
                    isc_pkg::MODE_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = isc_pkg::STATUS_BOUND;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = count_dec[AW-1:0];
                            state_next = isc_pkg::ST_RDWAIT;
                        end
                    end
                    isc_pkg::MODE_CLEAR:
                    begin
                        // Entries at or above the count are never read: drop the count only.
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = isc_pkg::ST_RESP;
                    end
                endcase
            end

            isc_pkg::ST_RDWAIT:
            begin
                res_value_next = ram_rdata;
                state_next     = isc_pkg::ST_RESP;
            end

            isc_pkg::ST_SHIFT:
            begin
                // Read the source, then write it to the gap in the following cycle.
                // Writes land strictly below every later read, so no hazard.
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = src_reg[AW-1:0];
                    src_next  = src_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    dst_next  = dst_reg + CW'(1);
                end
                if (!issue && !pend_reg)
                begin
                    // The gap has closed: the write pointer now sits at the new count.
                    count_next = dst_reg;
                    state_next = isc_pkg::ST_RESP;
                end
            end

            isc_pkg::ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = isc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = isc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isc_pkg::ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_xfer)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (req_xfer)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            cut_reg  <= (mode == isc_pkg::MODE_ERASE) ? 5'd1 : erase_count;
            item_reg <= item_value;
        end
        if (rsp_load)
        begin
            read_value_reg <= res_value_reg;
            status_reg     <= res_status_reg;
            fill_reg       <= count_x[isc_pkg::FILL_W-1:0];
            empty_reg      <= (count_reg == '0);
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign fill_count = fill_reg;
    assign is_empty   = empty_reg;

endmodule

// ----- rtl/core/isc_checker.sv -----
// Port-level checker for the indexed stack with compaction, with its bind.
// Depends on isc_pkg; attaches to indexed_stack_with_compaction.
module isc_checker #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [63:0] read_value,
    input logic [1:0]  status,
    input logic [4:0]  fill_count,
    input logic        is_empty
);

    localparam int XW = 12;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    // Hold a stalled result.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(status)
            && $stable(fill_count) && $stable(is_empty))
        else $error("stalled result changed");

    // One request at a time: a transfer makes the block busy next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (fill_count == 5'd0)))
        else $error("empty flag disagrees with fill count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != isc_pkg::STATUS_OK) |-> (read_value == 64'd0)
            && (status == isc_pkg::STATUS_BOUND || status == isc_pkg::STATUS_FULL))
        else $error("failed request returned data or bad status");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == isc_pkg::STATUS_FULL) |-> (fill_count == CAP_X[4:0]))
        else $error("full status below capacity");

endmodule

bind indexed_stack_with_compaction isc_checker #(
    .CAPACITY (CAPACITY)
) u_isc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_value (read_value),
    .status     (status),
    .fill_count (fill_count),
    .is_empty   (is_empty)
);

// ----- bench/tb_indexed_stack_with_compaction.sv -----
`timescale 1ns / 1ps
// Self-checking bench for indexed_stack_with_compaction: drives requests, tracks
// the vector in a shadow copy and checks every result transfer field by field.
// Depends on isc_pkg and the RTL of indexed_stack_with_compaction.
module tb_indexed_stack_with_compaction;

    localparam int CAPACITY    = 16;
    localparam int IDLE_PCT    = 27;
    localparam int TOTAL_ITEMS = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // One result as the block reports it
    typedef struct packed {
        logic [63:0] read_value;
        logic [1:0]  status;
        logic [4:0]  fill_count;
        logic        is_empty;
    } vector_result_t;

    logic        clk;
    logic        rst_n       = 1'b0;

    logic        req_valid   = 1'b0;
    logic        req_stall;
    logic [2:0]  mode        = isc_pkg::MODE_PUSH;
    logic [3:0]  position    = '0;
    logic [4:0]  erase_count = '0;
    logic [63:0] item_value  = '0;

    logic        rsp_valid;
    logic        rsp_stall   = 1'b0;
    logic [63:0] read_value;
    logic [1:0]  status;
    logic [4:0]  fill_count;
    logic        is_empty;

    // Shadow copy of the vector, updated at each accepted request transfer
    logic [63:0]    vector_store [CAPACITY];
    int             vector_count = 0;
    vector_result_t expected_results [$];

    int          sender_idle_pct      = IDLE_PCT;
    int          receiver_idle_pct    = IDLE_PCT;
    int          receiver_hold_cycles = 0;
    int          request_count        = 0;
    int          failure_count        = 0;
    int unsigned cycle_count          = 0;

    indexed_stack_with_compaction #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .position    (position),
        .erase_count (erase_count),
        .item_value  (item_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .read_value  (read_value),
        .status      (status),
        .fill_count  (fill_count),
        .is_empty    (is_empty)
    );

    // 8 ns clock: low half, then high half
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Count cycles and end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_indexed_stack_with_compaction: FAIL");
        $finish;
    end

    // Work out the result of one request and advance the shadow vector.
    // A failed request leaves the vector alone and reads back zero.
    function automatic vector_result_t predict_request(input logic [2:0]  op,
                                                       input logic [3:0]  pos,
                                                       input logic [4:0]  run,
                                                       input logic [63:0] value);
        vector_result_t r;
        int p;
        int n;
        int i;
        p = int'(pos);
        n = int'(run);
        r.read_value = '0;
        r.status     = isc_pkg::STATUS_OK;
        case (op)
            isc_pkg::MODE_PUSH:
            begin
                if (vector_count >= CAPACITY)
                    r.status = isc_pkg::STATUS_FULL;
                else
                begin
                    vector_store[vector_count] = value;
                    vector_count++;
                end
            end
            isc_pkg::MODE_POP:
            begin
                // Lower the count only; the entry stays in place
                if (vector_count == 0)
                    r.status = isc_pkg::STATUS_BOUND;
                else
                    vector_count--;
            end
            isc_pkg::MODE_GET:
            begin
                if (p >= vector_count)
                    r.status = isc_pkg::STATUS_BOUND;
                else
                    r.read_value = vector_store[p];
            end
            isc_pkg::MODE_SET:
            begin
                if (p >= vector_count)
                    r.status = isc_pkg::STATUS_BOUND;
                else
                    vector_store[p] = value;
            end
            isc_pkg::MODE_ERASE:
            begin
                if (p >= vector_count)
                    r.status = isc_pkg::STATUS_BOUND;
                else
                begin
                    for (i = p; i + 1 < vector_count; i++)
                        vector_store[i] = vector_store[i + 1];
                    vector_count--;
                end
            end
            isc_pkg::MODE_ERASE_RUN:
            begin
                // Reject a run that starts or ends past the fill count
                if (p >= vector_count || p + n > vector_count)
                    r.status = isc_pkg::STATUS_BOUND;
                else
                begin
                    for (i = p; i + n < vector_count; i++)
                        vector_store[i] = vector_store[i + n];
                    vector_count -= n;
                end
            end
            isc_pkg::MODE_BACK:
            begin
                if (vector_count == 0)
                    r.status = isc_pkg::STATUS_BOUND;
                else
                    r.read_value = vector_store[vector_count - 1];
            end
            default:
            begin
                for (i = 0; i < CAPACITY; i++)
                    vector_store[i] = '0;
                vector_count = 0;
            end
        endcase
        r.fill_count = vector_count[4:0];
        r.is_empty   = (vector_count == 0);
        return r;
    endfunction

    task automatic note_failure(input string what, input vector_result_t want,
                                input vector_result_t got);
        failure_count++;
        if (failure_count <= MAX_REPORTS)
            $display("%s: expected value %h status %0d fill %0d empty %0b,",
                     what, want.read_value, want.status, want.fill_count, want.is_empty,
                     " got value %h status %0d fill %0d empty %0b",
                     got.read_value, got.status, got.fill_count, got.is_empty);
    endtask

    // Check each result transfer against the oldest pending expectation
    always @(posedge clk)
    begin : result_check
        vector_result_t got;
        vector_result_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            got = '{read_value, status, fill_count, is_empty};
            if (expected_results.size() == 0)
                note_failure("result with no request pending", '0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got.read_value !== want.read_value || got.status !== want.status ||
                    got.fill_count !== want.fill_count || got.is_empty !== want.is_empty)
                    note_failure("result mismatch", want, got);
            end
        end
    end

    // Receiver: hold off for a counted stretch when asked, else stall at random
    always @(negedge clk)
    begin
        if (receiver_hold_cycles > 0)
        begin
            rsp_stall            <= 1'b1;
            receiver_hold_cycles <= receiver_hold_cycles - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Offer one request from a falling edge and hold it until the transfer.
    // Valid stays high on return so back-to-back requests need no gap.
    task automatic send_request(input logic [2:0] op, input logic [3:0] pos,
                                input logic [4:0] run, input logic [63:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        mode        = op;
        position    = pos;
        erase_count = run;
        item_value  = value;
        req_valid   = 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        expected_results.push_back(predict_request(op, pos, run, value));
        request_count++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every pending result
    task automatic hold_until_drained();
        req_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] random_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Build one random request, aiming most positions and runs inside the vector
    task automatic send_random_request();
        logic [2:0] op;
        logic [3:0] pos;
        logic [4:0] run;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 30)
            op = isc_pkg::MODE_PUSH;
        else if (pick < 40)
            op = isc_pkg::MODE_POP;
        else if (pick < 57)
            op = isc_pkg::MODE_GET;
        else if (pick < 69)
            op = isc_pkg::MODE_SET;
        else if (pick < 78)
            op = isc_pkg::MODE_ERASE;
        else if (pick < 87)
            op = isc_pkg::MODE_ERASE_RUN;
        else if (pick < 98)
            op = isc_pkg::MODE_BACK;
        else
            op = isc_pkg::MODE_CLEAR;
        if (vector_count > 0 && $urandom_range(9) < 8)
            pos = 4'($urandom_range(vector_count - 1));
        else
            pos = 4'($urandom_range(15));
        if (int'(pos) < vector_count && $urandom_range(9) < 8)
            run = 5'($urandom_range(vector_count - int'(pos)));
        else
            run = 5'($urandom_range(CAPACITY));
        send_request(op, pos, run, random_value());
    endtask

    // Each request but push on an empty vector: all but clear must fail
    task automatic test_empty_store_requests();
        send_request(isc_pkg::MODE_CLEAR, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_POP, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_BACK, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_GET, 4'd15, 5'd0, '0);
        send_request(isc_pkg::MODE_SET, 4'd0, 5'd0, '1);
        send_request(isc_pkg::MODE_ERASE, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_ERASE_RUN, 4'd0, 5'd0, '0);
    endtask

    // Extreme values, reads, edits and the erase run corner cases
    task automatic test_directed_edits();
        send_request(isc_pkg::MODE_PUSH, 4'd15, 5'd31, 64'h0);
        send_request(isc_pkg::MODE_PUSH, 4'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(isc_pkg::MODE_PUSH, 4'd0, 5'd0, 64'h5555_5555_5555_5555);
        send_request(isc_pkg::MODE_PUSH, 4'd0, 5'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(isc_pkg::MODE_GET, 4'd1, 5'd0, '0);
        send_request(isc_pkg::MODE_SET, 4'd2, 5'd0, 64'h8000_0000_0000_0001);
        send_request(isc_pkg::MODE_GET, 4'd2, 5'd0, '0);
        send_request(isc_pkg::MODE_BACK, 4'd0, 5'd0, '0);
        // Zero-length run inside the vector: ok, nothing moves
        send_request(isc_pkg::MODE_ERASE_RUN, 4'd1, 5'd0, '0);
        // Run past the end: rejected
        send_request(isc_pkg::MODE_ERASE_RUN, 4'd1, 5'd16, '0);
        send_request(isc_pkg::MODE_ERASE_RUN, 4'd1, 5'd2, '0);
        send_request(isc_pkg::MODE_GET, 4'd1, 5'd0, '0);
        send_request(isc_pkg::MODE_ERASE, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_ERASE, 4'd5, 5'd0, '0);
        send_request(isc_pkg::MODE_POP, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_POP, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_PUSH, 4'd0, 5'd0, 64'h0123_4567_89AB_CDEF);
        send_request(isc_pkg::MODE_CLEAR, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_BACK, 4'd0, 5'd0, '0);
    endtask

    // Hold off the receiver while pushing past capacity, so the block backs up
    // and the pushes on a full vector report full; then empty it in one run.
    task automatic test_backpressure_fill();
        int k;
        hold_until_drained();
        receiver_hold_cycles = 150;
        for (k = 0; k < CAPACITY + 2; k++)
            send_request(isc_pkg::MODE_PUSH, 4'($urandom_range(15)), 5'd0, random_value());
        send_request(isc_pkg::MODE_GET, 4'd15, 5'd0, '0);
        send_request(isc_pkg::MODE_BACK, 4'd0, 5'd0, '0);
        send_request(isc_pkg::MODE_ERASE_RUN, 4'd0, 5'd16, '0);
        hold_until_drained();
    endtask

    // Random traffic with neither side idling
    task automatic test_unbroken_stream();
        int k;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        for (k = 0; k < 150; k++)
            send_random_request();
        sender_idle_pct   = IDLE_PCT;
        receiver_idle_pct = IDLE_PCT;
    endtask

    // Move the fill count to a random level, full often, then mix requests
    task automatic test_random_sequences();
        int target;
        int k;
        while (request_count < TOTAL_ITEMS)
        begin
            target = ($urandom_range(3) == 0) ? CAPACITY : $urandom_range(CAPACITY);
            while (vector_count < target)
                send_request(isc_pkg::MODE_PUSH, 4'($urandom_range(15)),
                             5'($urandom_range(CAPACITY)), random_value());
            while (vector_count > target)
                send_request(isc_pkg::MODE_POP, 4'($urandom_range(15)), 5'd0, '0);
            if (vector_count == CAPACITY)
                send_request(isc_pkg::MODE_PUSH, 4'd0, 5'd0, random_value());
            for (k = 0; k < 12; k++)
                send_random_request();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_store_requests();
        test_directed_edits();
        test_backpressure_fill();
        test_unbroken_stream();
        test_random_sequences();

        // Drain, then watch a while longer for stray results
        hold_until_drained();
        repeat (CAPACITY + 8) @(posedge clk);

        if (failure_count == 0 && expected_results.size() == 0)
            $display("tb_indexed_stack_with_compaction: PASS");
        else
            $display("tb_indexed_stack_with_compaction: FAIL");
        $finish;
    end

endmodule
